// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sfr_pkg.sv
// ---------------------------------------------------------------------------
// sfr_pkg
// Types and constants of the sequenced fragment receiver.
// ---------------------------------------------------------------------------
package sfr_pkg;

  localparam int SEQ_W  = 31;
  localparam int MLEN_W = 15;
  localparam int CLEN_W = 11;
  localparam int VERD_W = 3;

  localparam logic [15:0] FRAGMENT_LEN = 16'd1300;
  localparam logic [15:0] MESSAGE_MAX  = 16'd16384;
  localparam logic [MLEN_W-1:0] CAPACITY_RESET = 15'd16384;

  localparam logic [VERD_W-1:0] VERDICT_DELIVER      = 3'd0;
  localparam logic [VERD_W-1:0] VERDICT_REASSEMBLED  = 3'd1;
  localparam logic [VERD_W-1:0] VERDICT_OUT_OF_ORDER = 3'd2;
  localparam logic [VERD_W-1:0] VERDICT_MISSED       = 3'd3;
  localparam logic [VERD_W-1:0] VERDICT_BAD_LENGTH   = 3'd4;
  localparam logic [VERD_W-1:0] VERDICT_STORED       = 3'd5;
  localparam logic [VERD_W-1:0] VERDICT_TOO_BIG      = 3'd6;

  typedef struct packed {
    logic [31:0]        header_word;
    logic signed [15:0] fragment_start;
    logic signed [15:0] fragment_length;
    logic [10:0]        payload_available;
  } sfr_in_t;

  typedef struct packed {
    logic [VERD_W-1:0] verdict;
    logic [SEQ_W-1:0]  sequence_number;
    logic [SEQ_W-1:0]  dropped_count;
    logic [MLEN_W-1:0] copy_offset;
    logic [CLEN_W-1:0] copy_length;
    logic [MLEN_W-1:0] message_length;
  } sfr_out_t;

  // Header after stateless classification.
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic              frag;
    logic              start_neg;
    logic [MLEN_W-1:0] start;
    logic              len_bad;
    logic [CLEN_W-1:0] len;
  } sfr_cls_t;

endpackage

// File: rtl/sfr_front.sv
// ---------------------------------------------------------------------------
// sfr_front
// Input stage: takes headers and classifies the fields that need no state.
// ---------------------------------------------------------------------------
module sfr_front
  import sfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sfr_in_t  in_data,
  output logic     cls_valid,
  input  logic     cls_full,
  output sfr_cls_t cls_data
);

  logic     vld_r, vld_nxt;
  sfr_cls_t cls_r, cls_nxt;
  logic     take;
  logic     len_neg;
  logic     len_over;

  assign in_stall = vld_r & cls_full;
  assign take     = in_valid & ~in_stall;

  always_comb begin
    len_neg  = in_data.fragment_length[15];
    len_over = {1'b0, in_data.fragment_length[14:0]} > {5'd0, in_data.payload_available};
    cls_nxt.seq       = in_data.header_word[SEQ_W-1:0];
    cls_nxt.frag      = in_data.header_word[31];
    cls_nxt.start_neg = in_data.fragment_start[15];
    cls_nxt.start     = in_data.fragment_start[MLEN_W-1:0];
    cls_nxt.len_bad   = len_neg | len_over;
    cls_nxt.len       = in_data.fragment_length[CLEN_W-1:0];
  end

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (!cls_full) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cls_r <= cls_nxt;
    end
  end

  assign cls_valid = vld_r;
  assign cls_data  = cls_r;

endmodule

// File: rtl/sfr_queue.sv
// ---------------------------------------------------------------------------
// sfr_queue
// Short register queue between the classifier and the sequencing stage.
// ---------------------------------------------------------------------------
module sfr_queue
  import sfr_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  sfr_cls_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output sfr_cls_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  sfr_cls_t          mem_r [DEPTH];
  logic [AW-1:0]     wptr_r, wptr_nxt;
  logic [AW-1:0]     rptr_r, rptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign pop_data  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == LAST) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == LAST) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/sfr_back.sv
// ---------------------------------------------------------------------------
// sfr_back
// Sequencing and reassembly state, verdict and registered result.
// ---------------------------------------------------------------------------
module sfr_back
  import sfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [MLEN_W-1:0] cfg_data,
  input  logic              q_valid,
  input  sfr_cls_t          q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output sfr_out_t          out_data
);

  logic [MLEN_W-1:0] cap_r;
  logic [SEQ_W-1:0]  last_r, last_nxt;
  logic [SEQ_W-1:0]  rseq_r, rseq_nxt;
  logic [MLEN_W-1:0] asm_r, asm_nxt;
  logic              ovld_r, ovld_nxt;
  sfr_out_t          out_r, res;
  logic [MLEN_W-1:0] eff_asm;
  logic [15:0]       sum;
  logic              load;

  assign load  = ~ovld_r | ~out_stall;
  assign q_pop = q_valid & load;

  always_comb begin
    last_nxt = last_r;
    rseq_nxt = rseq_r;
    asm_nxt  = asm_r;
    res      = '0;
    res.sequence_number = q_data.seq;
    eff_asm  = (q_data.seq != rseq_r) ? '0 : asm_r;
    sum      = {1'b0, eff_asm} + {5'd0, q_data.len};
    if (q_data.seq <= last_r) begin
      res.verdict = VERDICT_OUT_OF_ORDER;
    end else begin
      res.dropped_count = q_data.seq - last_r - 1'b1;
      if (!q_data.frag) begin
        last_nxt    = q_data.seq;
        res.verdict = VERDICT_DELIVER;
      end else begin
        rseq_nxt = q_data.seq;
        asm_nxt  = eff_asm;
        if (q_data.start_neg || q_data.start != eff_asm) begin
          res.verdict = VERDICT_MISSED;
        end else if (q_data.len_bad || sum > MESSAGE_MAX) begin
          res.verdict = VERDICT_BAD_LENGTH;
        end else begin
          res.copy_offset = eff_asm;
          res.copy_length = q_data.len;
          asm_nxt         = sum[MLEN_W-1:0];
          if ({5'd0, q_data.len} == FRAGMENT_LEN) begin
            res.verdict = VERDICT_STORED;
          end else if (sum[MLEN_W-1:0] > cap_r) begin
            res.verdict        = VERDICT_TOO_BIG;
            res.message_length = sum[MLEN_W-1:0];
          end else begin
            res.verdict        = VERDICT_REASSEMBLED;
            res.message_length = sum[MLEN_W-1:0];
            asm_nxt            = '0;
            last_nxt           = q_data.seq;
          end
        end
      end
    end
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (load) begin
      ovld_nxt = q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAPACITY_RESET;
      last_r <= '0;
      rseq_r <= '0;
      asm_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (q_pop) begin
        last_r <= last_nxt;
        rseq_r <= rseq_nxt;
        asm_r  <= asm_nxt;
      end
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= res;
    end
  end

  assign out_valid = ovld_r;
  assign out_data  = out_r;

endmodule

// File: rtl/sequenced_fragment_receiver.sv
// ---------------------------------------------------------------------------
// sequenced_fragment_receiver
// Receive-side sequence check and fragment reassembly bookkeeping.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one datagram header per transaction (valid/stall).
//   out_* : one verdict per header, in order (valid/stall), with the
//           dropped count, payload copy placement and reassembled length.
//   cfg_* : writes receive_capacity; always ready, apply only when idle.
// Path: from input transaction to result valid through the classify
//   register, queue and result register.
// Throughput: one header per cycle while no stall holds the flow; the
//   sequencing stage updates its state once per header.
// Reset: clears the sequence state, assembled length and queue, and sets
//   receive_capacity to 16384.
// Stall: the result register holds; the queue of QUEUE_DEPTH entries
//   absorbs headers, then in_stall rises until space frees up.
// ---------------------------------------------------------------------------
module sequenced_fragment_receiver
  import sfr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sfr_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sfr_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MLEN_W-1:0] cfg_data
);

  logic     cls_valid;
  logic     q_full;
  sfr_cls_t cls_data;
  logic     q_pop;
  logic     q_valid;
  sfr_cls_t q_data;

  assign cfg_ready = 1'b1;

  sfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cls_valid (cls_valid),
    .cls_full  (q_full),
    .cls_data  (cls_data)
  );

  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cls_valid),
    .push_data (cls_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  sfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/sfr_checker.sv
// ---------------------------------------------------------------------------
// sfr_checker
// Port-level assertions for the sequenced fragment receiver.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfr_checker
  import sfr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input sfr_out_t out_data
);

  `SFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
  `SFR_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled result changed")
  `SFR_ASSERT_NOW(a_ooo_clean, out_valid && out_data.verdict == VERDICT_OUT_OF_ORDER, out_data.dropped_count == '0 && out_data.copy_length == '0 && out_data.message_length == '0, "out of order result carries data")
  `SFR_ASSERT_NOW(a_no_copy, out_valid && (out_data.verdict == VERDICT_DELIVER || out_data.verdict == VERDICT_MISSED || out_data.verdict == VERDICT_BAD_LENGTH), out_data.copy_offset == '0 && out_data.copy_length == '0, "copy placement without stored fragment")
  `SFR_ASSERT_NOW(a_mlen, out_valid && out_data.verdict != VERDICT_REASSEMBLED && out_data.verdict != VERDICT_TOO_BIG, out_data.message_length == '0, "message length on non-final verdict")

endmodule

bind sequenced_fragment_receiver sfr_checker u_sfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for sequenced_fragment_receiver. A directed pass
// covers stale and plain datagrams, reassembly, gaps, bad lengths, the
// capacity and message size limits and the top of the sequence space.
// A random pass follows, mostly well-formed fragment trains with some noise,
// under several receive capacities, with bursty input, output stalls and a
// long output hold-off. Every result is compared field by field against an
// in-order queue filled by a predictor of the sequencing state.
// ---------------------------------------------------------------------------
module testbench;
  import sfr_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_LIMIT    = 50000;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int PRINT_LIMIT    = 200;
  localparam int MAX_AVAIL      = 1400;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  sfr_in_t           in_data;
  logic              out_valid;
  logic              out_stall;
  sfr_out_t          out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [MLEN_W-1:0] cfg_data;

  // predictor state
  logic [SEQ_W-1:0]  pred_last_seq;
  logic [SEQ_W-1:0]  pred_reasm_seq;
  logic [MLEN_W-1:0] pred_asm_len;
  logic [MLEN_W-1:0] pred_capacity;

  sfr_out_t    expected_verdicts[$];
  int          error_count;
  int          results_checked;
  int          items_sent;
  int          burst_left;
  bit          sender_gaps;
  bit          holdoff_request;
  stall_mode_t stall_mode;

  sequenced_fragment_receiver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("sequenced_fragment_receiver verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want_v);
    if (got !== want_v) begin
      report_mismatch($sformatf("result %0d %s: got %0d want %0d",
                                results_checked, name, got, want_v));
    end
  endtask

  function automatic sfr_out_t predict_verdict(input sfr_in_t hdr);
    sfr_out_t         res;
    logic [SEQ_W-1:0] seq;
    int               start;
    int               len;
    res   = '0;
    seq   = hdr.header_word[SEQ_W-1:0];
    start = $signed(hdr.fragment_start);
    len   = $signed(hdr.fragment_length);
    res.sequence_number = seq;
    if (seq <= pred_last_seq) begin
      res.verdict = VERDICT_OUT_OF_ORDER;
    end else begin
      res.dropped_count = seq - pred_last_seq - 1'b1;
      if (!hdr.header_word[31]) begin
        res.verdict   = VERDICT_DELIVER;
        pred_last_seq = seq;
      end else begin
        if (seq != pred_reasm_seq) begin
          pred_reasm_seq = seq;
          pred_asm_len   = '0;
        end
        if (start != int'(pred_asm_len)) begin
          res.verdict = VERDICT_MISSED;
        end else if (len < 0 || len > int'(hdr.payload_available) ||
                     int'(pred_asm_len) + len > int'(MESSAGE_MAX)) begin
          res.verdict = VERDICT_BAD_LENGTH;
        end else begin
          res.copy_offset = pred_asm_len;
          res.copy_length = len[CLEN_W-1:0];
          pred_asm_len    = pred_asm_len + len[MLEN_W-1:0];
          if (len == int'(FRAGMENT_LEN)) begin
            res.verdict = VERDICT_STORED;
          end else if (pred_asm_len > pred_capacity) begin
            res.verdict        = VERDICT_TOO_BIG;
            res.message_length = pred_asm_len;
          end else begin
            res.verdict        = VERDICT_REASSEMBLED;
            res.message_length = pred_asm_len;
            pred_asm_len       = '0;
            pred_last_seq      = seq;
          end
        end
      end
    end
    return res;
  endfunction

  task automatic send_header(input logic [31:0] word, input logic [15:0] start,
                             input logic [15:0] len, input logic [10:0] avail);
    sfr_in_t hdr;
    int      gap;
    hdr.header_word       = word;
    hdr.fragment_start    = start;
    hdr.fragment_length   = len;
    hdr.payload_available = avail;
    if (sender_gaps && burst_left <= 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= hdr;
    do @(posedge clk); while (in_stall);
    expected_verdicts.push_back(predict_verdict(hdr));
    items_sent++;
    burst_left--;
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [MLEN_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    pred_capacity = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SEQ_W-1:0] fresh_seq();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      return SEQ_W'(pred_last_seq + $urandom_range(1, 1 << 24));
    end else if (pick < 20) begin
      return SEQ_W'(pred_last_seq + $urandom_range(2, 6));
    end
    return pred_last_seq + 1'b1;
  endfunction

  // fragment train, mostly well formed; a few fragments get corrupted and
  // some trains are abandoned after a corruption
  task automatic send_random_message();
    logic [SEQ_W-1:0] seq;
    int               nfull;
    int               idx;
    int               start;
    int               len;
    int               avail;
    bit               abandon;
    seq     = fresh_seq();
    nfull   = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
    abandon = 1'b0;
    for (idx = 0; idx <= nfull && !abandon; idx++) begin
      len   = (idx < nfull) ? int'(FRAGMENT_LEN) : $urandom_range(0, MAX_AVAIL);
      avail = $urandom_range(len, MAX_AVAIL);
      start = (seq == pred_reasm_seq) ? int'(pred_asm_len) : 0;
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 3))
          0: start = $signed(16'($urandom));
          1: len = -int'($urandom_range(1, 32768));
          2: begin
            if (len > 0) avail = $urandom_range(0, len - 1);
            else start = start + 1;
          end
          default: start = start + $urandom_range(1, 1300);
        endcase
        abandon = ($urandom_range(0, 2) == 0);
      end
      send_header({1'b1, seq}, start[15:0], len[15:0], avail[10:0]);
    end
  endtask

  task automatic send_random_plain();
    send_header({1'b0, fresh_seq()}, 16'($urandom), 16'($urandom),
                11'($urandom_range(0, MAX_AVAIL)));
  endtask

  task automatic test_plain_and_stale();
    send_header(32'd1, 16'd0, 16'd0, 11'd0);
    send_header(32'd1, 16'd0, 16'd0, 11'd0);
    send_header(32'd0, 16'h7FFF, 16'h8000, 11'd1400);
    send_header(32'd4, 16'h8000, 16'h7FFF, 11'd1400);
    send_header(32'h8000_0003, 16'd0, 16'd10, 11'd10);
  endtask

  task automatic test_fragment_reassembly();
    send_header(32'h8000_0005, 16'd0, FRAGMENT_LEN, 11'd1300);
    send_header(32'h8000_0005, 16'd1300, FRAGMENT_LEN, 11'd1400);
    send_header(32'h8000_0005, 16'd2600, 16'd0, 11'd0);
    send_header(32'h8000_0007, 16'd0, 16'd1400, 11'd1400);
  endtask

  task automatic test_fragment_errors();
    send_header(32'h8000_0008, 16'd0, FRAGMENT_LEN, 11'd1400);
    send_header(32'h8000_0008, 16'd0, 16'd100, 11'd1400);          // duplicate start
    send_header(32'h8000_0008, -16'sd1300, 16'd100, 11'd1400);     // negative start
    send_header(32'h8000_0008, 16'd1300, -16'sd1, 11'd1400);       // negative length
    send_header(32'h8000_0008, 16'd1300, 16'd500, 11'd499);        // short payload
    send_header(32'h8000_0009, 16'd1300, 16'd10, 11'd10);          // new seq restarts
    send_header(32'h8000_0009, 16'd0, 16'd10, 11'd10);
    send_header(32'h8000_0008, 16'd1300, 16'd10, 11'd10);
  endtask

  task automatic test_capacity_limit();
    write_capacity(15'd1000);
    send_header(32'h8000_000A, 16'd0, 16'd1000, 11'd1000);
    send_header(32'h8000_000B, 16'd0, 16'd1001, 11'd1400);
    send_header(32'h8000_000B, 16'd1001, FRAGMENT_LEN, 11'd1400);
    send_header(32'h8000_000B, 16'd2301, 16'd5, 11'd5);
    write_capacity(15'd0);
    send_header(32'h8000_000C, 16'd0, 16'd0, 11'd0);
    send_header(32'h8000_000D, 16'd0, 16'd1, 11'd1);
    write_capacity(CAPACITY_RESET);
  endtask

  task automatic test_message_max();
    int idx;
    for (idx = 0; idx < 12; idx++) begin
      send_header(32'h8000_000E, 16'(idx * 1300), FRAGMENT_LEN, 11'd1300);
    end
    send_header(32'h8000_000E, 16'd15600, 16'd785, 11'd785);
    send_header(32'h8000_000E, 16'd15600, 16'd784, 11'd1400);
  endtask

  // output held off long enough that the queue fills and the input stalls
  task automatic test_backpressure();
    int idx;
    stall_mode      = STALL_NONE;
    sender_gaps     = 1'b0;
    holdoff_request = 1'b1;
    for (idx = 0; idx < 40; idx++) begin
      if (idx % 3 == 0) send_random_message();
      else send_random_plain();
    end
    wait_idle();
  endtask

  task automatic test_drain_pause();
    int round;
    stall_mode  = STALL_LIGHT;
    sender_gaps = 1'b1;
    for (round = 0; round < 4; round++) begin
      repeat (3) send_random_plain();
      send_random_message();
      wait_idle();
    end
  endtask

  task automatic test_random_traffic(input logic [MLEN_W-1:0] capacity,
                                     input stall_mode_t mode, input bit gaps,
                                     input int count);
    int target;
    int pick;
    write_capacity(capacity);
    stall_mode  = mode;
    sender_gaps = gaps;
    target      = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_random_message();
      end else if (pick < 75) begin
        send_random_plain();
      end else if (pick < 88) begin
        send_header({1'($urandom), 31'($urandom_range(pred_last_seq))},
                    16'($urandom), 16'($urandom), 11'($urandom_range(0, MAX_AVAIL)));
      end else begin
        send_header({1'b1, ($urandom_range(0, 1) ? pred_reasm_seq : fresh_seq())},
                    ($urandom_range(0, 1) ? 16'(pred_asm_len) : 16'($urandom)),
                    16'($urandom), 11'($urandom_range(0, MAX_AVAIL)));
      end
    end
  endtask

  task automatic test_sequence_top();
    write_capacity(CAPACITY_RESET);
    stall_mode  = STALL_HEAVY;
    sender_gaps = 1'b1;
    send_header({1'b0, 31'h7FFF_FFF0}, 16'd0, 16'd0, 11'd0);
    send_header({1'b1, 31'h7FFF_FFF5}, 16'd0, FRAGMENT_LEN, 11'd1400);
    send_header({1'b1, 31'h7FFF_FFF5}, 16'd1300, 16'd77, 11'd1400);
    send_header({1'b1, 1'b1, 30'($urandom)}, 16'($urandom), 16'($urandom), 11'd700);
    send_header({1'b0, 31'h7FFF_FFFF}, 16'hFFFF, 16'hFFFF, 11'd1400);
    send_header({1'b1, 31'h7FFF_FFFF}, 16'd0, 16'd10, 11'd10);
    send_header(32'hFFFF_FFFF, 16'd0, 16'd0, 11'd0);
  endtask

  initial begin : receiver_stall
    int hold_count;
    int phase_count;
    out_stall   = 1'b0;
    hold_count  = 0;
    phase_count = 0;
    forever begin
      @(negedge clk);
      phase_count++;
      if (holdoff_request) begin
        hold_count      = HOLDOFF_CYCLES;
        holdoff_request = 1'b0;
      end
      if (hold_count > 0) begin
        hold_count--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 7) == 0);
          STALL_HEAVY:    out_stall <= $urandom_range(0, 1);
          STALL_PERIODIC: out_stall <= ((phase_count % 11) < 4);
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  initial begin : result_checker
    sfr_out_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("result with no transaction pending, seq %0d",
                                    out_data.sequence_number));
        end else begin
          want = expected_verdicts.pop_front();
          check_field("verdict", 32'(out_data.verdict), 32'(want.verdict));
          check_field("sequence_number", 32'(out_data.sequence_number),
                      32'(want.sequence_number));
          check_field("dropped_count", 32'(out_data.dropped_count),
                      32'(want.dropped_count));
          check_field("copy_offset", 32'(out_data.copy_offset), 32'(want.copy_offset));
          check_field("copy_length", 32'(out_data.copy_length), 32'(want.copy_length));
          check_field("message_length", 32'(out_data.message_length),
                      32'(want.message_length));
          results_checked++;
        end
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    pred_last_seq   = '0;
    pred_reasm_seq  = '0;
    pred_asm_len    = '0;
    pred_capacity   = CAPACITY_RESET;
    error_count     = 0;
    results_checked = 0;
    items_sent      = 0;
    burst_left      = 0;
    sender_gaps     = 1'b1;
    holdoff_request = 1'b0;
    stall_mode      = STALL_LIGHT;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    test_plain_and_stale();
    test_fragment_reassembly();
    test_fragment_errors();
    test_capacity_limit();
    test_message_max();
    test_backpressure();
    test_drain_pause();
    test_random_traffic(CAPACITY_RESET, STALL_LIGHT, 1'b1, 300);
    test_random_traffic(15'd0, STALL_HEAVY, 1'b1, 250);
    test_random_traffic(15'($urandom_range(0, 16383)), STALL_PERIODIC, 1'b0, 300);
    test_random_traffic(15'd2000, STALL_NONE, 1'b0, 300);
    test_random_traffic(CAPACITY_RESET, STALL_HEAVY, 1'b1, 350);
    test_sequence_top();

    wait_idle();
    if (expected_verdicts.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_verdicts.size()));
    end
    if (error_count == 0) begin
      $display("sequenced_fragment_receiver verification clean");
    end else begin
      $display("sequenced_fragment_receiver verification failed");
    end
    $finish;
  end

endmodule
